FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sleep timer queue checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define STQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define STQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Types and constants shared by the sleep timer queue modules.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam logic       OP_SLEEP     = 1'b0;
  localparam logic       OP_TICK      = 1'b1;

  localparam logic       KIND_STATUS  = 1'b0;
  localparam logic       KIND_WAKE    = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NEG   = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [7:0] TPS_RESET    = 8'd10;

  typedef struct packed {
    logic               op;
    logic signed [23:0] seconds;
    logic        [15:0] waiter_id;
  } stq_req_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] woken_id;
    logic        last;
  } stq_res_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [31:0] wake_tick;
    logic [15:0] waiter;
  } stq_entry_t;

endpackage

FILE: rtl/stq_mem.sv
// ----------------------------------------------------------------------------
// stq_mem
// Sleeper table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stq_mem #(
  parameter int Depth = 32,
  parameter int IdxW  = 5
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  stq_pkg::stq_entry_t wdata_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  output stq_pkg::stq_entry_t rdata_o
);
  import stq_pkg::*;

  stq_entry_t mem_q [Depth];
  stq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/stq_wake.sv
// ----------------------------------------------------------------------------
// stq_wake
// Wake tick calculation: registered seconds x rate product, then a
// saturating add onto the current tick count.
// ----------------------------------------------------------------------------
module stq_wake (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [22:0] seconds_i,
  input  logic [7:0]  tps_i,
  input  logic [31:0] tick_i,
  output logic [31:0] wake_o
);
  import stq_pkg::*;

  logic [30:0] prod_d, prod_q;
  logic [32:0] sum;

  assign prod_d = {8'b0, seconds_i} * {23'b0, tps_i};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign sum    = {1'b0, tick_i} + {2'b0, prod_q};
  assign wake_o = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

endmodule

FILE: rtl/sleep_timer_queue.sv
// ----------------------------------------------------------------------------
// sleep_timer_queue
// Table of sleeping waiters with wake ticks, woken in insertion order by a
// clock tick.
// ----------------------------------------------------------------------------
// A rejected sleep request leaves busy low and its status word is registered.
// An accepted one registers the product of seconds and rate, then does the
// saturating add and the table write; its status word appears in the same
// cycle that busy drops. A clock tick walks the table through the single read
// port of the entry memory, one entry per cycle, and holds busy until the walk
// ends, also when the table is empty. A woken word is held back until the next
// due entry turns up or the walk ends, so the last one of a tick can carry last.
// Words are never held back by the receiver, so it must take every strobed word.
// Entries that stay are packed down in place during the same walk.
// ----------------------------------------------------------------------------
module sleep_timer_queue #(
  parameter int MAX_SLEEPERS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  stq_pkg::stq_req_t req_i,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  output logic             res_strobe_o,
  output stq_pkg::stq_res_t res_o
);
  import stq_pkg::*;

  localparam int IdxW = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
  localparam int CntW = $clog2(MAX_SLEEPERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADD  = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e          state_d, state_q;
  logic [7:0]      tps_q;
  logic [31:0]     tick_d, tick_q;
  logic [CntW-1:0] count_d, count_q;
  logic [CntW-1:0] rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] keep_d, keep_q;
  logic            vld_d, vld_q;
  logic            pend_d, pend_q;
  logic [15:0]     pend_id_d, pend_id_q;
  logic [15:0]     req_id_d, req_id_q;
  logic            strobe_d, strobe_q;
  stq_res_t        res_d, res_q;

  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr;
  stq_entry_t      mem_wdata, rd_data;
  logic            wake_load;
  logic [31:0]     wake_tick;
  logic            issue;

  stq_mem #(
    .Depth (MAX_SLEEPERS),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  stq_wake u_wake (
    .clk_i     (clk_i),
    .load_i    (wake_load),
    .seconds_i (req_i.seconds[22:0]),
    .tps_i     (tps_q),
    .tick_i    (tick_q),
    .wake_o    (wake_tick)
  );

  assign issue = (rd_ptr_q < count_q);

  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    count_d   = count_q;
    rd_ptr_d  = rd_ptr_q;
    keep_d    = keep_q;
    vld_d     = 1'b0;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    req_id_d  = req_id_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = keep_q[IdxW-1:0];
    mem_wdata = rd_data;
    wake_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_i.op == OP_TICK) begin
            if (tick_q != 32'hFFFF_FFFF) begin
              tick_d = tick_q + 32'd1;
            end
            rd_ptr_d = '0;
            keep_d   = '0;
            pend_d   = 1'b0;
            state_d  = ST_SCAN;
          end else begin
            req_id_d = req_i.waiter_id;
            if (req_i.seconds[23]) begin
              strobe_d = 1'b1;
              res_d    = '{kind: KIND_STATUS, status: STATUS_NEG,
                           woken_id: req_i.waiter_id, last: 1'b1};
            end else if (count_q == CntW'(MAX_SLEEPERS)) begin
              strobe_d = 1'b1;
              res_d    = '{kind: KIND_STATUS, status: STATUS_FULL,
                           woken_id: req_i.waiter_id, last: 1'b1};
            end else begin
              wake_load = 1'b1;
              state_d   = ST_ADD;
            end
          end
        end
      end
      ST_ADD: begin
        mem_we    = 1'b1;
        mem_waddr = count_q[IdxW-1:0];
        mem_wdata = '{wake_tick: wake_tick, waiter: req_id_q};
        count_d   = count_q + CntW'(1);
        strobe_d  = 1'b1;
        res_d     = '{kind: KIND_STATUS, status: STATUS_OK,
                      woken_id: req_id_q, last: 1'b1};
        state_d   = ST_IDLE;
      end
      ST_SCAN: begin
        if (issue) begin
          mem_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CntW'(1);
          vld_d    = 1'b1;
        end
        // wake words go out one entry late so the final one can carry last
        if (vld_q) begin
          if (rd_data.wake_tick <= tick_q) begin
            if (pend_q) begin
              strobe_d = 1'b1;
              res_d    = '{kind: KIND_WAKE, status: STATUS_OK,
                           woken_id: pend_id_q, last: 1'b0};
            end
            pend_d    = 1'b1;
            pend_id_d = rd_data.waiter;
          end else begin
            // keep_q never passes the entry being read, so no overlap
            mem_we = 1'b1;
            keep_d = keep_q + CntW'(1);
          end
        end
        if (!issue && !vld_q) begin
          count_d = keep_q;
          if (pend_q) begin
            strobe_d = 1'b1;
            res_d    = '{kind: KIND_WAKE, status: STATUS_OK,
                         woken_id: pend_id_q, last: 1'b1};
          end
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tps_q    <= TPS_RESET;
      tick_q   <= '0;
      count_q  <= '0;
      rd_ptr_q <= '0;
      keep_q   <= '0;
      vld_q    <= 1'b0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      tick_q   <= tick_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      keep_q   <= keep_d;
      vld_q    <= vld_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    req_id_q  <= req_id_d;
    res_q     <= res_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

FILE: rtl/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks of the sleep timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input stq_pkg::stq_req_t req_i,
  input logic              res_strobe_o,
  input stq_pkg::stq_res_t res_o
);
  import stq_pkg::*;

  // a status word always closes its request
  `STQ_ASSERT(a_status_last, clk_i, rst_ni, res_strobe_o && (res_o.kind == KIND_STATUS) |-> res_o.last, "status word without last")

  // negative duration is answered on the next cycle with the requester id
  `STQ_ASSERT(a_neg_reply, clk_i, rst_ni, start && !busy && (req_i.op == OP_SLEEP) && req_i.seconds[23] |=> res_strobe_o && (res_o.status == STATUS_NEG) && (res_o.woken_id == $past(req_i.waiter_id)), "negative sleep not rejected")

  // wake words always carry the accepted status
  `STQ_ASSERT(a_wake_status, clk_i, rst_ni, res_strobe_o && (res_o.kind == KIND_WAKE) |-> (res_o.status == STATUS_OK), "wake word with nonzero status")

  // a wake word without last means the walk is still going
  `STQ_ASSERT(a_wake_more, clk_i, rst_ni, res_strobe_o && (res_o.kind == KIND_WAKE) && !res_o.last |-> busy, "wake word without last while idle")

  // an accepted tick always starts a table walk
  `STQ_ASSERT(a_tick_busy, clk_i, rst_ni, start && !busy && (req_i.op == OP_TICK) |=> busy, "tick did not start a walk")

endmodule

bind sleep_timer_queue stq_checker u_stq_checker (.*);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sleep_timer_queue. Sleep requests and clock ticks go in as
// command words in random bursts. A shadow copy of the waiter table predicts
// every status and wake word, and each strobed word is checked in order. The
// run moves through several tick rates, among them 0, 1 and 255, and fills
// the table to its limit at least once.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam int SLOTS = 32;
  localparam int SETTLE_CYCLES = SLOTS + 8;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  stq_req_t  req_i;
  logic      cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic      res_strobe_o;
  stq_res_t  res_o;

  sleep_timer_queue #(.MAX_SLEEPERS(SLOTS)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  // shadow of the waiter table plus the words it still owes
  class sleep_table_shadow;
    logic [31:0] tick_now;
    logic [31:0] wake_at[SLOTS];
    logic [15:0] owner[SLOTS];
    int unsigned fill;
    logic [7:0]  rate;
    stq_res_t    coming_words[$];
    int unsigned n_err, n_words, n_ok, n_neg, n_full, n_woken, n_ticks, top_burst;

    function new();
      tick_now = '0;
      fill = 0;
      rate = TPS_RESET;
      n_err = 0;
      n_words = 0;
      n_ok = 0;
      n_neg = 0;
      n_full = 0;
      n_woken = 0;
      n_ticks = 0;
      top_burst = 0;
    endfunction

    function void set_rate(logic [7:0] v);
      rate = v;
    endfunction

    function void take_request(stq_req_t w);
      stq_res_t    r;
      logic [63:0] sum;
      logic [15:0] woke[$];
      int unsigned keep;
      if (w.op == OP_SLEEP) begin
        r.kind = KIND_STATUS;
        r.woken_id = w.waiter_id;
        r.last = 1'b1;
        if (w.seconds[23]) begin
          r.status = STATUS_NEG;
          n_neg++;
        end else if (fill >= SLOTS) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          sum = {32'd0, tick_now} + {41'd0, w.seconds[22:0]} * {56'd0, rate};
          wake_at[fill] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          owner[fill] = w.waiter_id;
          fill++;
          r.status = STATUS_OK;
          n_ok++;
        end
        coming_words.push_back(r);
      end else begin
        n_ticks++;
        if (tick_now != 32'hFFFF_FFFF) tick_now++;
        keep = 0;
        for (int unsigned i = 0; i < fill; i++) begin
          if (wake_at[i] <= tick_now) begin
            woke.push_back(owner[i]);
          end else begin
            wake_at[keep] = wake_at[i];
            owner[keep] = owner[i];
            keep++;
          end
        end
        fill = keep;
        for (int k = 0; k < woke.size(); k++) begin
          r.kind = KIND_WAKE;
          r.status = STATUS_OK;
          r.woken_id = woke[k];
          r.last = (k == woke.size() - 1);
          coming_words.push_back(r);
        end
        n_woken += woke.size();
        if (woke.size() > top_burst) top_burst = woke.size();
      end
    endfunction

    function void match_word(stq_res_t got);
      stq_res_t want;
      n_words++;
      if (coming_words.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch: unexpected word kind=%0d status=%0d id=%h last=%0d",
                   got.kind, got.status, got.woken_id, got.last);
        return;
      end
      want = coming_words.pop_front();
      if (got.kind !== want.kind || got.status !== want.status ||
          got.woken_id !== want.woken_id || got.last !== want.last) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch: expected kind=%0d status=%0d id=%h last=%0d, got kind=%0d status=%0d id=%h last=%0d",
                   want.kind, want.status, want.woken_id, want.last,
                   got.kind, got.status, got.woken_id, got.last);
      end
    endfunction
  endclass

  sleep_table_shadow sb;

  initial begin
    clk_i = 1'b0;
    sb = new();
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result words cannot be held off, so every strobe is taken
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) sb.match_word(res_o);
  end

  function automatic stq_req_t mk_word(logic op, logic [23:0] sec, logic [15:0] id);
    stq_req_t w;
    w.op = op;
    w.seconds = sec;
    w.waiter_id = id;
    return w;
  endfunction

  function automatic stq_req_t pick_word();
    logic [23:0] sec;
    int unsigned span;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return mk_word(OP_TICK, 24'($urandom), 16'($urandom));
    span = (sb.rate == 0) ? 60 : 12 / sb.rate;
    roll = $urandom_range(0, 99);
    if (roll < 10)
      sec = {1'b1, 23'($urandom)};
    else if (roll < ((sb.rate == 0) ? 45 : 14))
      sec = {1'b0, 23'($urandom)};
    else
      sec = 24'($urandom_range(0, span));
    return mk_word(OP_SLEEP, sec, 16'($urandom));
  endfunction

  // start is raised here and left high; the caller lowers it before a gap
  task automatic send_word(input stq_req_t w);
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    sb.take_request(w);
  endtask

  task automatic wait_drained();
    while (sb.coming_words.size() != 0) @(posedge clk_i);
  endtask

  // a tick with nothing due gives no word, so allow a full table walk first
  task automatic write_rate(input logic [7:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_rate(v);
  endtask

  task automatic drive_items(input int count);
    int k;
    int burst;
    int gap;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && k < count) begin
        send_word(pick_word());
        burst--;
        k++;
      end
      if ($urandom_range(0, 11) == 0) begin
        start <= 1'b0;
        wait_drained();
        @(posedge clk_i);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    start <= 1'b0;
  endtask

  // pack the table, poke it while full, then drain it with a few ticks
  task automatic fill_table();
    while (sb.fill < SLOTS)
      send_word(mk_word(OP_SLEEP, 24'($urandom_range(0, 3)), 16'($urandom)));
    send_word(mk_word(OP_SLEEP, 24'd2, 16'($urandom)));
    send_word(mk_word(OP_SLEEP, {1'b1, 23'($urandom)}, 16'($urandom)));
    repeat (5) send_word(mk_word(OP_TICK, '0, '0));
  endtask

  initial begin
    int fails;
    int guard;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset rate
    send_word(mk_word(OP_TICK, '0, '0));
    send_word(mk_word(OP_SLEEP, 24'd0, 16'h0000));
    send_word(mk_word(OP_SLEEP, 24'hFFFFFF, 16'hFFFF));
    send_word(mk_word(OP_SLEEP, 24'h800000, 16'h1234));
    send_word(mk_word(OP_SLEEP, 24'h7FFFFF, 16'hFFFF));
    send_word(mk_word(OP_SLEEP, 24'd1, 16'h00AA));
    send_word(mk_word(OP_TICK, '0, '0));
    send_word(mk_word(OP_SLEEP, 24'd0, 16'h5555));
    send_word(mk_word(OP_SLEEP, 24'd0, 16'hAAAA));
    send_word(mk_word(OP_SLEEP, 24'd0, 16'h0F0F));
    repeat (9) send_word(mk_word(OP_TICK, '0, '0));
    start <= 1'b0;

    write_rate(8'd1);
    fill_table();
    drive_items(40);
    write_rate(8'd0);
    drive_items(40);
    write_rate(8'($urandom_range(2, 254)));
    drive_items(35);
    write_rate(8'd255);
    drive_items(35);

    guard = 0;
    while (sb.coming_words.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    fails = sb.n_err + sb.coming_words.size();
    $display("covered: %0d sleeps taken, %0d negative, %0d on a full table, %0d ticks",
             sb.n_ok, sb.n_neg, sb.n_full, sb.n_ticks);
    $display("covered: %0d waiters woken, at most %0d on one tick, %0d words checked",
             sb.n_woken, sb.top_burst, sb.n_words);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_mem.sv
rtl/stq_wake.sv
rtl/sleep_timer_queue.sv
rtl/stq_checker.sv
test/tb_top.sv
